>>> hdl/hmap_pkg.sv
// Shared constants, codes and types of the linear-probing hash map.
package hmap_pkg;

    localparam int CFG_BITS           = 9;
    localparam int COUNT_BITS         = 9;
    localparam int CMD_BITS           = 2;
    localparam int STATUS_BITS        = 2;
    localparam int MARK_BITS          = 2;
    localparam int CAP_RESET          = 256;
    localparam int DEFAULT_SLOTS      = 256;
    localparam int DEFAULT_KEY_BITS   = 32;
    localparam int DEFAULT_VALUE_BITS = 32;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_INSERT = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_REMOVE = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_BITS-1:0] {
        STATUS_OK     = 2'd0,
        STATUS_ABSENT = 2'd1,
        STATUS_FULL   = 2'd2
    } status_t;

    typedef enum logic [MARK_BITS-1:0] {
        MARK_EMPTY = 2'd0,
        MARK_LIVE  = 2'd1,
        MARK_TOMB  = 2'd2
    } mark_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_RESP
    } state_t;

endpackage

>>> hdl/hmap_if.sv
// Handshake interfaces for the request, response and capacity channels.
interface hmap_req_if import hmap_pkg::*; #(
    parameter int KEY_BITS   = DEFAULT_KEY_BITS,
    parameter int VALUE_BITS = DEFAULT_VALUE_BITS
);
    logic                  valid;
    logic                  ready;
    logic [CMD_BITS-1:0]   command;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;

    modport source (output valid, command, key, value, input ready);
    modport sink   (input valid, command, key, value, output ready);
endinterface

interface hmap_rsp_if import hmap_pkg::*; #(
    parameter int VALUE_BITS = DEFAULT_VALUE_BITS
);
    logic                   valid;
    logic                   ready;
    logic [STATUS_BITS-1:0] status;
    logic [VALUE_BITS-1:0]  found_value;
    logic [COUNT_BITS-1:0]  entry_count;

    modport source (output valid, status, found_value, entry_count, input ready);
    modport sink   (input valid, status, found_value, entry_count, output ready);
endinterface

interface hmap_cfg_if import hmap_pkg::*;;
    logic                valid;
    logic                ready;
    logic [CFG_BITS-1:0] table_capacity;

    modport source (output valid, table_capacity, input ready);
    modport sink   (input valid, table_capacity, output ready);
endinterface

>>> hdl/linear_probe_hash_map.sv
// Top level of the linear-probing hash map: sequencer, slot memory and remainder unit.
//
// The block stores key/value pairs in open-addressed slots with linear probing.
// A request item carries a command (insert or update, lookup, remove), a key and a
// value; each request gives one response item with a status, the value
// found by a lookup and the live entry count after the operation.
// The capacity channel writes the slot count in use (zero reads as one, values
// above SLOTS saturate). A write drops any request in flight, zeroes the count
// and empties the slots in use. After reset the capacity is the smaller of 256 and SLOTS.
//
// Flow: an item passes through the bit-serial remainder unit that forms the
// home slot, then a walk over the probed slots (up to the capacity), then the
// response register.
// The block holds one item at a time; request.ready is low from acceptance
// until the response item has been taken, so a stalled receiver simply holds
// the response and blocks new requests.
// After reset and after every capacity write, a clearing pass marks the slots
// in use empty, one slot per cycle (256 slots after reset by default); no
// request is accepted during the pass. Capacity writes are always accepted
// and restart the pass.
module linear_probe_hash_map import hmap_pkg::*; #(
    parameter int SLOTS      = DEFAULT_SLOTS,
    parameter int KEY_BITS   = DEFAULT_KEY_BITS,
    parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
    input  logic      clk,
    input  logic      rst_n,
    hmap_req_if.sink  request,
    hmap_rsp_if.source response,
    hmap_cfg_if.sink  cfg
);

    localparam int IDX_BITS  = $clog2(SLOTS);
    localparam int WORD_BITS = MARK_BITS + KEY_BITS + VALUE_BITS;
    localparam logic [CFG_BITS-1:0] CAP_INIT =
        CFG_BITS'((CAP_RESET > SLOTS) ? SLOTS : CAP_RESET);

    // Control state.
    state_t                state_reg;
    state_t                state_next;
    logic [CFG_BITS-1:0]   cap_reg;
    logic [CFG_BITS-1:0]   cap_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic [IDX_BITS-1:0]   idx_reg;
    logic [IDX_BITS-1:0]   idx_next;
    logic [IDX_BITS-1:0]   step_reg;
    logic [IDX_BITS-1:0]   step_next;
    logic                  free_ok_reg;
    logic                  free_ok_next;

    // Item payload and response registers.
    logic [CMD_BITS-1:0]   cmd_reg;
    logic [CMD_BITS-1:0]   cmd_next;
    logic [KEY_BITS-1:0]   key_reg;
    logic [KEY_BITS-1:0]   key_next;
    logic [VALUE_BITS-1:0] value_reg;
    logic [VALUE_BITS-1:0] value_next;
    logic [IDX_BITS-1:0]   free_reg;
    logic [IDX_BITS-1:0]   free_next;
    status_t               status_reg;
    status_t               status_next;
    logic [VALUE_BITS-1:0] found_reg;
    logic [VALUE_BITS-1:0] found_next;

    // Handshakes.
    logic                  req_fire;
    logic                  rsp_fire;
    logic                  cfg_fire;
    logic [CFG_BITS-1:0]   cap_sat;

    // Remainder unit.
    logic                  rem_done;
    logic [IDX_BITS-1:0]   rem_home;

    // Slot memory ports.
    logic                  mem_we;
    logic [IDX_BITS-1:0]   mem_waddr;
    logic [WORD_BITS-1:0]  mem_wdata;
    logic [WORD_BITS-1:0]  mem_rdata;

    // Probe decode of the slot read at idx_reg.
    mark_t                 rd_mark;
    logic [KEY_BITS-1:0]   rd_key;
    logic [VALUE_BITS-1:0] rd_value;
    logic [IDX_BITS-1:0]   last_idx;
    logic [IDX_BITS-1:0]   wrap_idx;
    logic                  is_empty;
    logic                  is_tomb;
    logic                  is_hit;
    logic                  free_any;
    logic [IDX_BITS-1:0]   free_slot;
    logic                  probe_finish;

    assign req_fire = request.valid && request.ready;
    assign rsp_fire = response.valid && response.ready;
    assign cfg_fire = cfg.valid && cfg.ready;

    // Capacity is always writable; a write during a request would drop it, so
    // requests wait while a write is offered.
    assign cfg.ready     = 1'b1;
    assign request.ready = (state_reg == S_IDLE) && !cfg.valid;

    assign response.valid       = (state_reg == S_RESP);
    assign response.status      = status_reg;
    assign response.found_value = found_reg;
    assign response.entry_count = count_reg;

    always_comb
    begin
        if (cfg.table_capacity == '0)
        begin
            cap_sat = CFG_BITS'(1);
        end
        else if (32'(cfg.table_capacity) > 32'(SLOTS))
        begin
            cap_sat = CFG_BITS'(SLOTS);
        end
        else
        begin
            cap_sat = cfg.table_capacity;
        end
    end

    assign last_idx = IDX_BITS'(cap_reg - CFG_BITS'(1));
    assign wrap_idx = (idx_reg == last_idx) ? '0 : idx_reg + IDX_BITS'(1);

    // Memory word layout: mark, key, value from the top bit down.
    assign rd_mark  = mark_t'(mem_rdata[WORD_BITS-1 -: MARK_BITS]);
    assign rd_key   = mem_rdata[VALUE_BITS +: KEY_BITS];
    assign rd_value = mem_rdata[VALUE_BITS-1:0];

    // Any mark other than empty or tombstone is treated as a live entry.
    assign is_empty  = (rd_mark == MARK_EMPTY);
    assign is_tomb   = (rd_mark == MARK_TOMB);
    assign is_hit    = !is_empty && !is_tomb && (rd_key == key_reg);
    assign free_any  = free_ok_reg || is_empty || is_tomb;
    assign free_slot = free_ok_reg ? free_reg : idx_reg;

    // The walk ends on a match, on an empty slot, or once every slot in use
    // has been visited.
    assign probe_finish = is_hit || is_empty || (step_reg == last_idx);

    hmap_rem #(
        .KEY_BITS (KEY_BITS),
        .IDX_BITS (IDX_BITS)
    ) u_rem (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (req_fire),
        .key_in (request.key),
        .cap    (cap_reg),
        .done   (rem_done),
        .home   (rem_home)
    );

    hmap_mem #(
        .DEPTH     (SLOTS),
        .ADDR_BITS (IDX_BITS),
        .WORD_BITS (WORD_BITS)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (idx_next),
        .rd_data (mem_rdata)
    );

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (idx_reg == last_idx)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_fire)
                begin
                    if (request.command == CMD_INSERT || request.command == CMD_LOOKUP
                        || request.command == CMD_REMOVE)
                    begin
                        state_next = S_HASH;
                    end
                    else
                    begin
                        state_next = S_RESP;
                    end
                end
            end
            S_HASH:
            begin
                if (rem_done)
                begin
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (probe_finish)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (rsp_fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        // A capacity write always restarts the clearing pass.
        if (cfg_fire)
        begin
            state_next = S_CLEAR;
        end
    end

    // Datapath and memory control of the sequencer.
    always_comb
    begin
        cap_next     = cap_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        step_next    = step_reg;
        free_ok_next = free_ok_reg;
        free_next    = free_reg;
        cmd_next     = cmd_reg;
        key_next     = key_reg;
        value_next   = value_reg;
        status_next  = status_reg;
        found_next   = found_reg;
        mem_we       = 1'b0;
        mem_waddr    = idx_reg;
        mem_wdata    = {MARK_EMPTY, {KEY_BITS{1'b0}}, {VALUE_BITS{1'b0}}};

        case (state_reg)
            S_CLEAR:
            begin
                mem_we   = 1'b1;
                idx_next = idx_reg + IDX_BITS'(1);
            end
            S_IDLE:
            begin
                if (req_fire)
                begin
                    cmd_next    = request.command;
                    key_next    = request.key;
                    value_next  = request.value;
                    status_next = STATUS_ABSENT;
                    found_next  = '0;
                end
            end
            S_HASH:
            begin
                if (rem_done)
                begin
                    idx_next     = rem_home;
                    step_next    = '0;
                    free_ok_next = 1'b0;
                end
            end
            S_PROBE:
            begin
                // Remember the first reusable slot along the path.
                if ((is_empty || is_tomb) && !free_ok_reg)
                begin
                    free_ok_next = 1'b1;
                    free_next    = idx_reg;
                end
                if (probe_finish)
                begin
                    case (cmd_reg)
                        CMD_INSERT:
                        begin
                            if (is_hit)
                            begin
                                mem_we      = 1'b1;
                                mem_waddr   = idx_reg;
                                mem_wdata   = {MARK_LIVE, key_reg, value_reg};
                                status_next = STATUS_OK;
                            end
                            else if (free_any)
                            begin
                                mem_we      = 1'b1;
                                mem_waddr   = free_slot;
                                mem_wdata   = {MARK_LIVE, key_reg, value_reg};
                                count_next  = count_reg + COUNT_BITS'(1);
                                status_next = STATUS_OK;
                            end
                            else
                            begin
                                status_next = STATUS_FULL;
                            end
                        end
                        CMD_LOOKUP:
                        begin
                            if (is_hit)
                            begin
                                found_next  = rd_value;
                                status_next = STATUS_OK;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (is_hit)
                            begin
                                mem_we      = 1'b1;
                                mem_waddr   = idx_reg;
                                mem_wdata   = {MARK_TOMB, key_reg, value_reg};
                                status_next = STATUS_OK;
                                if (count_reg != '0)
                                begin
                                    count_next = count_reg - COUNT_BITS'(1);
                                end
                            end
                        end
                        default:
                        begin
                            status_next = STATUS_ABSENT;
                        end
                    endcase
                end
                else
                begin
                    idx_next  = wrap_idx;
                    step_next = step_reg + IDX_BITS'(1);
                end
            end
            S_RESP:
            begin
                idx_next = idx_reg;
            end
            default:
            begin
                idx_next = idx_reg;
            end
        endcase

        if (cfg_fire)
        begin
            cap_next   = cap_sat;
            count_next = '0;
            idx_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            cap_reg     <= CAP_INIT;
            count_reg   <= '0;
            idx_reg     <= '0;
            step_reg    <= '0;
            free_ok_reg <= 1'b0;
            status_reg  <= STATUS_ABSENT;
        end
        else
        begin
            state_reg   <= state_next;
            cap_reg     <= cap_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            step_reg    <= step_next;
            free_ok_reg <= free_ok_next;
            status_reg  <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        key_reg   <= key_next;
        value_reg <= value_next;
        free_reg  <= free_next;
        found_reg <= found_next;
    end

    // The live count can never exceed the slots in use.
    assert property (@(posedge clk) disable iff (!rst_n)
        COUNT_BITS'(count_reg) <= COUNT_BITS'(cap_reg))
        else $error("live count above capacity");

    // A probe walk stays inside the slots in use.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PROBE) |-> (idx_reg <= last_idx) && (step_reg <= last_idx))
        else $error("probe walk outside the slots in use");

    // Slots change during a walk only when the walk ends.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PROBE) && mem_we |-> probe_finish)
        else $error("slot written in the middle of a probe walk");

    // A capacity write empties the table and starts a clearing pass.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_fire |=> (state_reg == S_CLEAR) && (count_reg == '0) && (idx_reg == '0))
        else $error("capacity write did not restart the clearing pass");

endmodule

>>> hdl/hmap_rem.sv
// Bit-serial remainder unit: key modulo capacity, one key bit per cycle.
module hmap_rem import hmap_pkg::*; #(
    parameter int KEY_BITS = DEFAULT_KEY_BITS,
    parameter int IDX_BITS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [KEY_BITS-1:0] key_in,
    input  logic [CFG_BITS-1:0] cap,
    output logic                done,
    output logic [IDX_BITS-1:0] home
);

    localparam int CNT_BITS = $clog2(KEY_BITS + 1);

    logic                busy_reg;
    logic                busy_next;
    logic                done_reg;
    logic                done_next;
    logic [CNT_BITS-1:0] cnt_reg;
    logic [CNT_BITS-1:0] cnt_next;
    logic [KEY_BITS-1:0] shift_reg;
    logic [KEY_BITS-1:0] shift_next;
    logic [CFG_BITS-1:0] rem_reg;
    logic [CFG_BITS-1:0] rem_next;
    logic [CFG_BITS:0]   trial;
    logic [CFG_BITS:0]   diff;

    // Shift in the next key bit and subtract the capacity once if it fits.
    assign trial = {rem_reg, shift_reg[KEY_BITS-1]};
    assign diff  = trial - {1'b0, cap};

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            shift_next = key_in;
            rem_next   = '0;
        end
        else if (busy_reg)
        begin
            rem_next   = (trial >= {1'b0, cap}) ? diff[CFG_BITS-1:0] : trial[CFG_BITS-1:0];
            shift_next = shift_reg << 1;
            cnt_next   = cnt_reg + CNT_BITS'(1);
            if (cnt_reg == CNT_BITS'(KEY_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
    end

    assign done = done_reg;
    assign home = IDX_BITS'(rem_reg);

    // A result only appears at the end of a running division.
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("remainder done without a running division");

endmodule

>>> hdl/hmap_mem.sv
// Slot memory: one write port, one read port with registered read data.
module hmap_mem #(
    parameter int DEPTH     = 256,
    parameter int ADDR_BITS = 8,
    parameter int WORD_BITS = 66
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [WORD_BITS-1:0] wr_data,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [WORD_BITS-1:0] rd_data
);

    logic [WORD_BITS-1:0] mem [DEPTH];
    logic [WORD_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
